[rtl/smh_pkg.sv]
// Shared constants, types and state codes for the symbol mismatch histogram.
// Used by smh_distance, smh_bin_ram and symbol_mismatch_histogram; no dependencies.
package smh_pkg;

   localparam int MAX_SYMBOLS = 32;
   localparam int COUNT_BITS  = 32;
   localparam int NBINS       = MAX_SYMBOLS + 1;
   localparam int BIN_BITS    = $clog2(NBINS);

   localparam int WORD_BITS   = 64;
   localparam int SLOTS       = 32;
   localparam int LEN_BITS    = 6;
   localparam int DIST_BITS   = 6;
   localparam int OUT_BITS    = 32;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_QUERY_VALUE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WORD_LENGTH = 1'b1;

   localparam logic MODE_COMPARE = 1'b0;
   localparam logic MODE_READ    = 1'b1;

   localparam logic [LEN_BITS-1:0]   LENGTH_RESET = LEN_BITS'(MAX_SYMBOLS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } smh_state_type;

   typedef struct packed {
      logic                  rd_en;
      logic [BIN_BITS-1:0]   rd_addr;
      logic                  wr_en;
      logic [BIN_BITS-1:0]   wr_addr;
      logic [COUNT_BITS-1:0] wr_data;
   } smh_ram_req_type;

endpackage

[rtl/smh_distance.sv]
// Mismatch counter: masks the XOR of target and query words to the word length
// and counts differing symbols with an adder tree. Depends on smh_pkg.
module smh_distance
   import smh_pkg::*;
(
   input  logic [WORD_BITS-1:0] word_value,
   input  logic [WORD_BITS-1:0] query_value,
   input  logic [LEN_BITS-1:0]  word_length,
   output logic [DIST_BITS-1:0] distance
);

   logic [LEN_BITS-1:0]  eff_len;
   logic [WORD_BITS-1:0] diff;
   logic [SLOTS-1:0]     flags;
   logic [1:0]           lvl1 [16];
   logic [2:0]           lvl2 [8];
   logic [3:0]           lvl3 [4];
   logic [4:0]           lvl4 [2];

   // A zero length counts one symbol; lengths past the widest word are clipped.
   always_comb begin
      priority if (word_length == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (word_length > LEN_BITS'(MAX_SYMBOLS)) begin
         eff_len = LEN_BITS'(MAX_SYMBOLS);
      end else begin
         eff_len = word_length;
      end
   end

   assign diff = word_value ^ query_value;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         flags[i] = (diff[2*i] | diff[2*i+1]) & (LEN_BITS'(i) < eff_len);
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         lvl1[i] = {1'b0, flags[2*i]} + {1'b0, flags[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
      end
   end

   assign distance = DIST_BITS'({1'b0, lvl4[0]} + {1'b0, lvl4[1]});

endmodule

[rtl/smh_bin_ram.sv]
// Histogram bin memory: one write and one registered read per cycle, with a
// valid bit per bin so that bins read as zero until first written. Depends on smh_pkg.
module smh_bin_ram
   import smh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  smh_ram_req_type       ram_req,
   output logic [COUNT_BITS-1:0] rd_count
);

   logic [COUNT_BITS-1:0] mem [NBINS];
   logic [NBINS-1:0]      valid_ff;
   logic [NBINS-1:0]      valid_in;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  rd_hit_ff;
   logic                  rd_hit_in;

   always_comb begin
      valid_in = valid_ff;
      if (ram_req.wr_en) begin
         valid_in[ram_req.wr_addr] = 1'b1;
      end
   end

   assign rd_hit_in = ram_req.rd_en ? valid_ff[ram_req.rd_addr] : rd_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_count = rd_hit_ff ? rd_data_ff : '0;

endmodule

[rtl/symbol_mismatch_histogram.sv]
// Top level of the symbol mismatch histogram: request capture, sequencer,
// bin update and result registers. Depends on smh_pkg, smh_distance and smh_bin_ram.
//
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// req_mode selects the operation. In compare mode req_word_value is matched
// against the query word over the configured word length; the number of
// differing two-bit symbols picks a histogram bin, which is incremented
// (holding at its maximum count) and reported. In read mode the bin named by
// req_bin_index is reported unchanged; an index past the last bin reports zero.
// Each request yields exactly one result, shown for one cycle with rsp_valid
// high. The receiver cannot stall, so results are never held back.
// Timing: the result is registered after the bin lookup and bin update states.
// busy is high for the lookup and update cycles, and a new request may be
// accepted in the cycle the result is shown, so a request is not taken
// before the last one is through. That is set by the read-modify-write of
// the bin memory, whose read data is registered after the address.
// Configuration: csr_we writes the query word (index 0) or the word length
// (index 1) at once; write only while the block is idle.
// Reset clears all bins to zero through per-bin valid bits, so the block is
// ready as soon as reset is released. Query resets to 0 and length to 32.
module symbol_mismatch_histogram
   import smh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_mode,
   input  logic [WORD_BITS-1:0]    req_word_value,
   input  logic [DIST_BITS-1:0]    req_bin_index,
   output logic                    rsp_valid,
   output logic [DIST_BITS-1:0]    rsp_distance,
   output logic [OUT_BITS-1:0]     rsp_bin_count,
   output logic                    rsp_saturated,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_wdata
);

   smh_state_type         state_ff, state_in;

   // Configuration registers.
   logic [WORD_BITS-1:0]  query_ff;
   logic [LEN_BITS-1:0]   length_ff;

   // Captured request.
   logic                  mode_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic [DIST_BITS-1:0]  idx_ff;

   // Lookup results carried into the update cycle.
   logic [DIST_BITS-1:0]  key_ff, key_in;
   logic                  in_range_ff, in_range_in;

   // Result registers.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_BITS-1:0]  rsp_distance_ff, rsp_distance_in;
   logic [OUT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic                  accept;
   logic [DIST_BITS-1:0]  distance;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] new_count;
   logic [COUNT_BITS-1:0] report_count;
   smh_ram_req_type       ram_req;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   smh_distance u_distance (
      .word_value  (word_ff),
      .query_value (query_ff),
      .word_length (length_ff),
      .distance    (distance)
   );

   smh_bin_ram u_bin_ram (
      .clock    (clock),
      .reset    (reset),
      .ram_req  (ram_req),
      .rd_count (cur_count)
   );

   // Sequencer: capture, look up the bin, then write it back (compare mode) and report.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The incremented count holds at the maximum once the bin is full.
   assign new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);

   always_comb begin
      if (mode_ff == MODE_COMPARE) begin
         report_count = new_count;
      end else if (in_range_ff) begin
         report_count = cur_count;
      end else begin
         report_count = '0;
      end
   end

   // Datapath controls for each state.
   always_comb begin
      ram_req         = '0;
      key_in          = key_ff;
      in_range_in     = in_range_ff;
      rsp_valid_in    = 1'b0;
      rsp_distance_in = rsp_distance_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_sat_in      = rsp_sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LOOKUP: begin
            // Compare requests always land on a real bin; reads may not.
            key_in      = (mode_ff == MODE_COMPARE) ? distance : idx_ff;
            in_range_in = (mode_ff == MODE_COMPARE) || (idx_ff <= DIST_BITS'(MAX_SYMBOLS));
            ram_req.rd_en   = in_range_in;
            ram_req.rd_addr = in_range_in ? BIN_BITS'(key_in) : '0;
         end
         ST_UPDATE: begin
            ram_req.wr_en   = (mode_ff == MODE_COMPARE);
            ram_req.wr_addr = BIN_BITS'(key_ff);
            ram_req.wr_data = new_count;
            rsp_valid_in    = 1'b1;
            rsp_distance_in = key_ff;
            rsp_count_in    = OUT_BITS'(report_count);
            rsp_sat_in      = in_range_ff && (report_count == COUNT_MAX);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         query_ff     <= '0;
         length_ff    <= LENGTH_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_QUERY_VALUE: query_ff  <= csr_wdata;
               CSR_WORD_LENGTH: length_ff <= csr_wdata[LEN_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         word_ff <= req_word_value;
         idx_ff  <= req_bin_index;
      end
      key_ff          <= key_in;
      in_range_ff     <= in_range_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_sat_ff      <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_bin_count = rsp_count_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
